FILE: rtl/aef_pkg.sv
// Shared types and constants for the archive entry framer.
// No dependencies; used by every module in the rtl folder.

package aef_pkg;

    // Entry marker: three prefix bytes followed by the final byte.
    localparam logic [23:0] MARK_PREFIX = 24'h324458;
    localparam logic [7:0]  MARK_LAST   = 8'h39;

    // Header layout, counted from the first marker byte.
    localparam logic [31:0] HEADER_LEN  = 32'h18;
    localparam logic [3:0]  HEADER_INIT = 4'h4;
    localparam logic [3:0]  SIZE_FIRST  = 4'h8;
    localparam logic [3:0]  SIZE_LAST   = 4'hB;

    // Distance from the last size byte to the payload start.
    localparam logic [31:0] START_ADJ = HEADER_LEN - 32'(SIZE_LAST);

    // Header bytes still to skip after the last size byte.
    localparam logic [32:0] SKIP_TAIL = 33'(HEADER_LEN) - 33'(SIZE_LAST) - 33'd1;

    // Parser mode, one-hot.
    typedef enum logic [2:0] {
        MODE_SCAN   = 3'b001,
        MODE_HEADER = 3'b010,
        MODE_SKIP   = 3'b100
    } t_mode;

    // One input transaction as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_archive;
    } t_in_item;

    // Handshake between the input register and the framer core.
    typedef struct packed {
        logic valid;
        logic take;
    } t_stage_ctl;

endpackage

FILE: rtl/aef_in_reg.sv
// Input register of the archive entry framer.
// Depends on aef_pkg for the item type.

module aef_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_archive,
    input  logic              i_take,
    output aef_pkg::t_in_item o_item,
    output logic              o_valid
);

    logic              r_valid;
    logic              n_valid;
    aef_pkg::t_in_item r_item;
    logic              w_accept;

    // The register frees up in the same cycle the core consumes it.
    assign o_in_ready = !r_valid || i_take;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload capture on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.data_byte      <= i_data_byte;
            r_item.end_of_archive <= i_end_of_archive;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

FILE: rtl/aef_core.sv
// Framer core: marker scan, header parse, payload skip and result register.
// Depends on aef_pkg for constants, the mode enum and the item type.

module aef_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aef_pkg::t_in_item   i_item,
    input  logic                i_item_valid,
    output aef_pkg::t_stage_ctl o_ctl,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_entry_index,
    output logic [31:0]         o_payload_start,
    output logic [31:0]         o_payload_size
);

    // Parser state.
    aef_pkg::t_mode r_mode;
    aef_pkg::t_mode n_mode;
    logic [31:0]    r_pos;
    logic [31:0]    n_pos;
    logic [23:0]    r_recent;
    logic [23:0]    n_recent;
    logic [1:0]     r_run;
    logic [1:0]     n_run;
    logic [3:0]     r_hdr_off;
    logic [3:0]     n_hdr_off;
    logic [31:0]    r_size_acc;
    logic [31:0]    n_size_acc;
    logic [32:0]    r_skip;
    logic [32:0]    n_skip;
    logic [15:0]    r_count;
    logic [15:0]    n_count;

    // Result register.
    logic           r_out_valid;
    logic           n_out_valid;
    logic [15:0]    r_entry_index;
    logic [31:0]    r_payload_start;
    logic [31:0]    r_payload_size;

    logic           w_take;
    logic           w_result;
    logic [31:0]    w_size_full;
    logic [32:0]    w_skip_dec;

    // Consume the held item when the result register can take its outcome.
    assign w_take = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_ctl  = '{valid: i_item_valid, take: w_take};

    assign w_size_full = {i_item.data_byte, r_size_acc[23:0]};
    assign w_skip_dec  = (r_skip != 33'd0) ? (r_skip - 33'd1) : r_skip;

    // Next-state logic for one byte.
    always_comb begin
        n_mode     = r_mode;
        n_recent   = r_recent;
        n_run      = r_run;
        n_hdr_off  = r_hdr_off;
        n_size_acc = r_size_acc;
        n_skip     = r_skip;
        n_count    = r_count;
        w_result   = 1'b0;

        unique case (r_mode)
            aef_pkg::MODE_HEADER: begin
                // Offsets 8 to 11 carry the size, least significant byte first.
                if (r_hdr_off[3]) begin
                    case (r_hdr_off[1:0])
                        2'd0:    n_size_acc[7:0]   = i_item.data_byte;
                        2'd1:    n_size_acc[15:8]  = i_item.data_byte;
                        2'd2:    n_size_acc[23:16] = i_item.data_byte;
                        default: n_size_acc[31:24] = i_item.data_byte;
                    endcase
                end
                if (r_hdr_off == aef_pkg::SIZE_LAST) begin
                    w_result = 1'b1;
                    n_count  = r_count + 16'd1;
                    n_skip   = {1'b0, w_size_full} + aef_pkg::SKIP_TAIL;
                    n_mode   = aef_pkg::MODE_SKIP;
                end else begin
                    n_hdr_off = r_hdr_off + 4'd1;
                end
            end
            aef_pkg::MODE_SKIP: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == 33'd0) begin
                    n_mode   = aef_pkg::MODE_SCAN;
                    n_run    = 2'd0;
                    n_recent = 24'd0;
                end
            end
            default: begin
                // Scanning; the full marker must lie after the resume point.
                if (r_run == 2'd3 && r_recent == aef_pkg::MARK_PREFIX &&
                    i_item.data_byte == aef_pkg::MARK_LAST) begin
                    n_mode     = aef_pkg::MODE_HEADER;
                    n_hdr_off  = aef_pkg::HEADER_INIT;
                    n_size_acc = 32'd0;
                    n_run      = 2'd0;
                    n_recent   = 24'd0;
                end else begin
                    n_recent = {r_recent[15:0], i_item.data_byte};
                    if (r_run != 2'd3) begin
                        n_run = r_run + 2'd1;
                    end
                end
            end
        endcase

        n_pos = r_pos + 32'd1;

        // The final byte of an archive returns all parser state to reset.
        if (i_item.end_of_archive) begin
            n_mode     = aef_pkg::MODE_SCAN;
            n_pos      = 32'd0;
            n_recent   = 24'd0;
            n_run      = 2'd0;
            n_hdr_off  = 4'd0;
            n_size_acc = 32'd0;
            n_skip     = 33'd0;
            n_count    = 16'd0;
        end
    end

    // Output valid: loaded with each consumed item, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = w_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Parser state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= aef_pkg::MODE_SCAN;
            r_pos       <= 32'd0;
            r_recent    <= 24'd0;
            r_run       <= 2'd0;
            r_hdr_off   <= 4'd0;
            r_size_acc  <= 32'd0;
            r_skip      <= 33'd0;
            r_count     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_mode     <= n_mode;
                r_pos      <= n_pos;
                r_recent   <= n_recent;
                r_run      <= n_run;
                r_hdr_off  <= n_hdr_off;
                r_size_acc <= n_size_acc;
                r_skip     <= n_skip;
                r_count    <= n_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_take && w_result) begin
            r_entry_index   <= r_count;
            r_payload_start <= r_pos + aef_pkg::START_ADJ;
            r_payload_size  <= w_size_full;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_entry_index   = r_entry_index;
    assign o_payload_start = r_payload_start;
    assign o_payload_size  = r_payload_size;

endmodule

FILE: rtl/archive_entry_framer.sv
// Top level of the archive entry framer: input register plus framer core.
// Depends on aef_pkg, aef_in_reg and aef_core.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------------
//  input   | i_in_valid / o_in_ready | i_data_byte, i_end_of_archive
//  output  | o_out_valid/i_out_ready | o_entry_index, o_payload_start, o_payload_size
//
// One byte per clock is sustained while the output is not stalled; a result
// becomes valid once its byte has passed the input register and the core has
// loaded the result register. Throughput is set by the parser state update in the core.
// Reset is synchronous and active low; it clears all parser state.
// A stalled output holds its result while the input register still takes one
// more byte; after that o_in_ready drops until the result is taken.

module archive_entry_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_archive,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_entry_index,
    output logic [31:0] o_payload_start,
    output logic [31:0] o_payload_size
);

    aef_pkg::t_in_item   w_item;
    logic                w_item_valid;
    aef_pkg::t_stage_ctl w_ctl;

    aef_in_reg u_in_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_archive (i_end_of_archive),
        .i_take           (w_ctl.take),
        .o_item           (w_item),
        .o_valid          (w_item_valid)
    );

    aef_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_item),
        .i_item_valid    (w_item_valid),
        .o_ctl           (w_ctl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_entry_index   (o_entry_index),
        .o_payload_start (o_payload_start),
        .o_payload_size  (o_payload_size)
    );

`ifndef SYNTHESIS
    // A new result only follows a transaction consumed by the core.
    a_result_from_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctl.take))
        else $error("result appeared without a consumed transaction");

    // An empty input register always accepts.
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_item_valid |-> o_in_ready)
        else $error("input register empty but not ready");

    // With a stalled result and a held byte, nothing more may enter.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && w_item_valid) |-> !o_in_ready)
        else $error("input accepted while both stages are full");

    // The core never consumes from an empty input register.
    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.take |-> w_ctl.valid)
        else $error("core consumed an empty input register");
`endif

endmodule
